### design/image_frame_receiver_crc16_assert.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef IMAGE_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define IMAGE_FRAME_RECEIVER_CRC16_ASSERT_SVH

`ifndef SYNTH
// Check under reset: the property is not evaluated while reset is low.
`define IFRCRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that also holds during reset.
`define IFRCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IFRCRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IFRCRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/ifrcrc_pkg.sv
// Types, constants and the CRC byte update for the framed image receiver.
package ifrcrc_pkg;

    localparam int unsigned CFG_W  = 24;
    localparam int unsigned SIZE_W = 24;

    localparam logic [7:0]        SOF_CODE_RST = 8'hAA;
    localparam logic [7:0]        EOF_CODE_RST = 8'h55;
    localparam logic [7:0]        IMG_KIND_RST = 8'h01;
    localparam logic [SIZE_W-1:0] EXP_SIZE_RST = 24'd150528;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        CFG_SOF_CODE = 2'd0,
        CFG_EOF_CODE = 2'd1,
        CFG_IMG_KIND = 2'd2,
        CFG_EXP_SIZE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCLO = 3'd4,
        PH_CRCHI = 3'd5,
        PH_END   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TYPE    = 3'd1,
        ST_SIZE    = 3'd2,
        ST_CRC     = 3'd3,
        ST_ENDM    = 3'd4,
        ST_TIMEOUT = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]        sof_code;
        logic [7:0]        eof_code;
        logic [7:0]        img_kind;
        logic [SIZE_W-1:0] exp_size;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              is_payload;
        logic [7:0]        payload_byte;
        logic [SIZE_W-1:0] payload_index;
        logic              frame_done;
        t_status           frame_status;
    } t_result;

    // CRC-16/CCITT-FALSE, MSB first, one byte per call.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### design/ifrcrc_core.sv
// Frame parser state machine with running CRC; one step per beat.
module ifrcrc_core
    import ifrcrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_func,
    input  logic [7:0] i_byte,
    input  t_cfg    i_cfg,
    output t_result o_res
);

`include "image_frame_receiver_crc16_assert.svh"

    t_phase            r_phase, n_phase;
    logic [1:0]        r_field, n_field;
    logic [SIZE_W-1:0] r_len, n_len;
    logic [SIZE_W-1:0] r_count, n_count;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;

    logic              w_fin;
    t_status           w_fin_st;
    logic [SIZE_W-1:0] w_count_inc;

    assign w_count_inc = r_count + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_field  <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_field  = r_field;
        n_len    = r_len;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        w_fin    = 1'b0;
        w_fin_st = ST_OK;
        o_res    = '0;

        if (i_step) begin
            if (i_func) begin
                // timeout inside the payload is ignored
                if (r_phase != PH_DATA) begin
                    w_fin    = 1'b1;
                    w_fin_st = ST_TIMEOUT;
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_byte == i_cfg.sof_code) begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        if (i_byte != i_cfg.img_kind) begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_TYPE;
                        end else begin
                            n_phase = PH_LEN;
                            n_field = '0;
                            n_len   = '0;
                        end
                    end
                    PH_LEN: begin
                        case (r_field)
                            2'd0: begin
                                n_len[7:0] = i_byte;
                                n_field    = r_field + 1'b1;
                            end
                            2'd1: begin
                                n_len[15:8] = i_byte;
                                n_field     = r_field + 1'b1;
                            end
                            2'd2: begin
                                n_len[23:16] = i_byte;
                                n_field      = r_field + 1'b1;
                            end
                            default: begin
                                // top byte must be zero for the 32-bit length to match
                                n_field = '0;
                                if (i_byte != 8'h00 || r_len != i_cfg.exp_size) begin
                                    w_fin    = 1'b1;
                                    w_fin_st = ST_SIZE;
                                end else begin
                                    n_count = '0;
                                    n_crc   = CRC_INIT;
                                    n_phase = (i_cfg.exp_size == '0) ? PH_CRCLO : PH_DATA;
                                end
                            end
                        endcase
                    end
                    PH_DATA: begin
                        o_res.valid         = 1'b1;
                        o_res.is_payload    = 1'b1;
                        o_res.payload_byte  = i_byte;
                        o_res.payload_index = r_count;
                        n_crc   = crc16_byte(r_crc, i_byte);
                        n_count = w_count_inc;
                        if (w_count_inc >= i_cfg.exp_size || w_count_inc == '0) begin
                            n_phase = PH_CRCLO;
                        end
                    end
                    PH_CRCLO: begin
                        n_crc_lo = i_byte;
                        n_phase  = PH_CRCHI;
                    end
                    PH_CRCHI: begin
                        if ({i_byte, r_crc_lo} != r_crc) begin
                            w_fin    = 1'b1;
                            w_fin_st = ST_CRC;
                        end else begin
                            n_phase = PH_END;
                        end
                    end
                    PH_END: begin
                        w_fin    = 1'b1;
                        w_fin_st = (i_byte == i_cfg.eof_code) ? ST_OK : ST_ENDM;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end

            // end of frame: emit status and hunt again
            if (w_fin) begin
                o_res.valid        = 1'b1;
                o_res.frame_done   = 1'b1;
                o_res.frame_status = w_fin_st;
                n_phase  = PH_HUNT;
                n_field  = '0;
                n_len    = '0;
                n_count  = '0;
                n_crc    = CRC_INIT;
                n_crc_lo = '0;
            end
        end
    end

    `IFRCRC_ASSERT(a_idle_no_result, i_clk, i_rst_n, !i_step |-> !o_res.valid, "result without step")
    `IFRCRC_ASSERT(a_done_hunts, i_clk, i_rst_n, (i_step && o_res.frame_done) |=> (r_phase == PH_HUNT), "no hunt after frame end")
    `IFRCRC_ASSERT(a_data_timeout, i_clk, i_rst_n, (i_step && i_func && r_phase == PH_DATA) |-> !o_res.valid, "payload timeout not ignored")

endmodule

### design/image_frame_receiver_crc16.sv
// Framed image receiver: start marker hunt, header check, payload out, CRC-16 check.
// Each beat is held in the input register, and its result in the result register.
// Throughput: one beat per cycle while results are taken; the CRC byte update is a single combinational step.
// A result held at the output stalls intake once the input register is full as well.
// Reset: synchronous active-low i_rst_n; hunts for the start marker, parser and configuration registers take defaults.
module image_frame_receiver_crc16
    import ifrcrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input stream
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] rx_byte
    input  logic             i_s_axis_tuser,   // [0] func (1 = wait timeout)
    // result stream
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [7:0] payload_byte, [31:8] payload_index,
                                               // [34:32] frame_status, [39:35] zero
    output logic [1:0]       o_m_axis_tuser,   // [0] is_payload, [1] frame_done
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

`include "image_frame_receiver_crc16_assert.svh"

    // configuration registers
    t_cfg r_cfg;

    // input stage
    logic       r_in_valid;
    logic       r_in_func;
    logic [7:0] r_in_byte;

    // result stage
    logic    r_out_valid;
    t_result r_out;

    t_result w_res;
    logic    w_advance;

    // Advance the input beat through the parser whenever the result slot can take it.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sof_code <= SOF_CODE_RST;
            r_cfg.eof_code <= EOF_CODE_RST;
            r_cfg.img_kind <= IMG_KIND_RST;
            r_cfg.exp_size <= EXP_SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SOF_CODE: r_cfg.sof_code <= i_cfg_wdata[7:0];
                CFG_EOF_CODE: r_cfg.eof_code <= i_cfg_wdata[7:0];
                CFG_IMG_KIND: r_cfg.img_kind <= i_cfg_wdata[7:0];
                CFG_EXP_SIZE: r_cfg.exp_size <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the input beat until the parser consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_func <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
    end

    ifrcrc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_func  (r_in_func),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Load a new result on advance; drop the held one once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out.frame_status, r_out.payload_index,
                              r_out.payload_byte};
    assign o_m_axis_tuser  = {r_out.frame_done, r_out.is_payload};

    `IFRCRC_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_m_axis_tready) |-> !w_advance, "held result overwritten")
    `IFRCRC_ASSERT(a_one_kind, i_clk, i_rst_n, o_m_axis_tvalid |-> $onehot(o_m_axis_tuser), "result kind not unique")
    `IFRCRC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "stages not empty after reset")

endmodule

### tb/image_frame_receiver_crc16_tb.sv
// Self-checking testbench for the framed image receiver with CRC-16 check.
module image_frame_receiver_crc16_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifrcrc_pkg::*;

    // Results pass the input and result registers; allow margin before config writes and at the end.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with work pending but no beat moving on either side before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    // Length of the long receiver hold-off that backs the block up into its input.
    localparam int HOLD_CYCLES   = 400;
    // Input beats to queue in total before the random part stops.
    localparam int TOTAL_BEATS   = 1050;
    // Cap on printed mismatch lines; mismatches beyond it are still counted.
    localparam int PRINT_CAP     = 100;

    // Ways a generated frame may be broken.
    typedef enum int {
        FL_NONE,     // well-formed frame
        FL_TO_DATA,  // timeout inside payload, must be ignored
        FL_CRC,      // corrupted CRC
        FL_ENDM,     // wrong end marker
        FL_TYPE,     // wrong type byte
        FL_SIZE,     // length field differs from the configured size
        FL_TO_HDR,   // timeout within the header
        FL_TO_TAIL   // timeout within the CRC or before the end marker
    } t_flaw;

    // One input beat: func travels on tuser, the received byte on tdata.
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_rx_beat;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic             i_s_axis_tuser = 1'b0;    // [0] func
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [39:0]      o_m_axis_tdata;           // [7:0] byte, [31:8] index, [34:32] status
    logic [1:0]       o_m_axis_tuser;           // [0] is_payload, [1] frame_done
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = 2'd0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    image_frame_receiver_crc16 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Beats waiting to be driven, and frame results the block still owes.
    t_rx_beat    rx_beat_q[$];
    t_result     frame_result_q[$];

    // Shadow of the configuration registers, kept in step with every write.
    t_cfg        cfg_shadow;

    // Expected receiver state.
    t_phase      rx_phase;
    logic [1:0]  len_idx;
    logic [31:0] len_acc;
    logic [23:0] pay_cnt;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo_rx;

    // Traffic shaping: idle mix and hold-off request set by the stimulus process, hold-off count by its counter.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        press_req = 1'b0;
    int          hold_cnt = 0;

    int          err_cnt = 0;
    int          beats_queued = 0;
    int          beats_in = 0;
    int          payload_seen = 0;
    int          status_seen[8];
    int          quiet_cycles = 0;
    t_rx_beat    cur_beat;

    // CRC-16/CCITT-FALSE byte update, one feedback bit at a time, MSB first.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return r;
    endfunction

    // Drop back to hunting with all per-frame state cleared.
    function automatic void restart_hunt();
        rx_phase  = PH_HUNT;
        len_idx   = 2'd0;
        len_acc   = 32'd0;
        pay_cnt   = 24'd0;
        crc_acc   = 16'hFFFF;
        crc_lo_rx = 8'd0;
    endfunction

    // Build the status result that ends a frame, then hunt again.
    function automatic bit close_frame(input t_status st, output t_result r);
        r              = '0;
        r.valid        = 1'b1;
        r.frame_done   = 1'b1;
        r.frame_status = st;
        restart_hunt();
        return 1'b1;
    endfunction

    // Advance the expected receiver by one beat; returns 1 when the beat yields a result.
    function automatic bit frame_step(input logic to, input logic [7:0] b, output t_result r);
        logic [23:0] next_cnt;
        r = '0;
        if (to) begin
            // a wait timeout is harmless only while payload is streaming
            if (rx_phase == PH_DATA) return 1'b0;
            return close_frame(ST_TIMEOUT, r);
        end
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg_shadow.sof_code) rx_phase = PH_TYPE;
                return 1'b0;
            end
            PH_TYPE: begin
                if (b != cfg_shadow.img_kind) return close_frame(ST_TYPE, r);
                rx_phase = PH_LEN;
                len_idx  = 2'd0;
                len_acc  = 32'd0;
                return 1'b0;
            end
            PH_LEN: begin
                len_acc = len_acc | (32'(b) << (8 * len_idx));
                if (len_idx != 2'd3) begin
                    len_idx = len_idx + 2'd1;
                    return 1'b0;
                end
                len_idx = 2'd0;
                // all 32 bits count, so a nonzero top byte is always a size error
                if (len_acc != {8'd0, cfg_shadow.exp_size}) return close_frame(ST_SIZE, r);
                pay_cnt  = 24'd0;
                crc_acc  = 16'hFFFF;
                rx_phase = (cfg_shadow.exp_size == 24'd0) ? PH_CRCLO : PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                r.valid         = 1'b1;
                r.is_payload    = 1'b1;
                r.payload_byte  = b;
                r.payload_index = pay_cnt;
                crc_acc         = crc_ccitt_step(crc_acc, b);
                next_cnt        = pay_cnt + 24'd1;
                pay_cnt         = next_cnt;
                // the size register may have shrunk under a running payload
                if (next_cnt >= cfg_shadow.exp_size || next_cnt == 24'd0) rx_phase = PH_CRCLO;
                return 1'b1;
            end
            PH_CRCLO: begin
                crc_lo_rx = b;
                rx_phase  = PH_CRCHI;
                return 1'b0;
            end
            PH_CRCHI: begin
                if ({b, crc_lo_rx} != crc_acc) return close_frame(ST_CRC, r);
                rx_phase = PH_END;
                return 1'b0;
            end
            PH_END: begin
                return close_frame((b == cfg_shadow.eof_code) ? ST_OK : ST_ENDM, r);
            end
            default: begin
                restart_hunt();
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Input driver: hold a beat until taken, feed the predictor on every handshake.
    always @(posedge i_clk) begin : drive_blk
        t_result want;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                beats_in++;
                if (frame_step(cur_beat.func, cur_beat.rx_byte, want))
                    frame_result_q.push_back(want);
            end
            if (rx_beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_beat = rx_beat_q.pop_front();
                i_s_axis_tdata  <= cur_beat.rx_byte;
                i_s_axis_tuser  <= cur_beat.func;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off counter; starts on request from the stimulus process.
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (press_req) begin
            hold_cnt <= HOLD_CYCLES;
        end
    end

    // Receiver ready: random stalls, forced low while a hold-off runs.
    always @(posedge i_clk) begin
        i_m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: compare each taken beat against the oldest expectation.
    always @(posedge i_clk) begin : check_blk
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_result_q.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", o_m_axis_tdata[31:0], 0);
            end else begin
                want = frame_result_q.pop_front();
                check_field("is_payload", o_m_axis_tuser[0], want.is_payload);
                check_field("payload_byte", o_m_axis_tdata[7:0], want.payload_byte);
                check_field("payload_index", o_m_axis_tdata[31:8], want.payload_index);
                check_field("frame_done", o_m_axis_tuser[1], want.frame_done);
                check_field("frame_status", o_m_axis_tdata[34:32], want.frame_status);
                if (want.frame_done) status_seen[want.frame_status]++;
                else payload_seen++;
            end
        end
    end

    // Watchdog: count cycles where work is pending and nothing moves.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (rx_beat_q.size() == 0 && !i_s_axis_tvalid && frame_result_q.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, frame_result_q.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_beat(input logic f, input logic [7:0] b);
        rx_beat_q.push_back('{func: f, rx_byte: b});
        beats_queued++;
    endtask

    // Hunt-phase noise: a timeout or a byte that cannot open a frame.
    task automatic queue_noise();
        logic [7:0] b;
        if ($urandom_range(3) == 0) begin
            push_beat(1'b1, 8'($urandom));
        end else begin
            b = 8'($urandom);
            while (b == cfg_shadow.sof_code) b = 8'($urandom);
            push_beat(1'b0, b);
        end
    endtask

    // Queue one frame for the current configuration, broken as the flaw says.
    task automatic queue_frame(input t_flaw flaw_in);
        t_flaw       flaw;
        logic [31:0] len;
        logic [15:0] crc;
        logic [7:0]  b;
        int          n;
        int          cut;
        int          to_at;
        int          spot;
        flaw = flaw_in;
        n    = int'(cfg_shadow.exp_size);
        // never start a payload that is too long to send
        if (n > 64 && flaw != FL_TYPE && flaw != FL_TO_HDR) flaw = FL_SIZE;
        push_beat(1'b0, cfg_shadow.sof_code);
        if (flaw == FL_TO_HDR) begin
            cut = $urandom_range(4);
            if (cut != 0) push_beat(1'b0, cfg_shadow.img_kind);
            for (int i = 1; i < cut; i++) push_beat(1'b0, 8'(n >> (8 * (i - 1))));
            push_beat(1'b1, 8'($urandom));
            return;
        end
        if (flaw == FL_TYPE) begin
            push_beat(1'b0, cfg_shadow.img_kind ^ 8'($urandom_range(1, 255)));
            return;
        end
        push_beat(1'b0, cfg_shadow.img_kind);
        len = n;
        if (flaw == FL_SIZE) len = len ^ (32'h1 << $urandom_range(31));
        for (int i = 0; i < 4; i++) push_beat(1'b0, len[8*i +: 8]);
        if (flaw == FL_SIZE) return;
        to_at = -1;
        if (flaw == FL_TO_DATA && n > 0) to_at = $urandom_range(n - 1);
        crc = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            if (i == to_at) push_beat(1'b1, 8'($urandom));
            b = 8'($urandom);
            push_beat(1'b0, b);
            crc = crc_ccitt_step(crc, b);
        end
        if (flaw == FL_CRC) crc = crc ^ (16'h1 << $urandom_range(15));
        spot = (flaw == FL_TO_TAIL) ? $urandom_range(2) : 3;
        for (int i = 0; i < 3; i++) begin
            if (spot == i) begin
                push_beat(1'b1, 8'($urandom));
                return;
            end
            if (i < 2) push_beat(1'b0, crc[8*i +: 8]);
        end
        // a CRC mismatch closes the frame before the end marker
        if (flaw == FL_CRC) return;
        push_beat(1'b0, (flaw == FL_ENDM) ?
                  cfg_shadow.eof_code ^ 8'($urandom_range(1, 255)) : cfg_shadow.eof_code);
    endtask

    function automatic t_flaw pick_flaw();
        int r;
        r = $urandom_range(99);
        if (r < 45) return FL_NONE;
        if (r < 60) return FL_TO_DATA;
        if (r < 68) return FL_CRC;
        if (r < 76) return FL_ENDM;
        if (r < 84) return FL_TYPE;
        if (r < 92) return FL_SIZE;
        if (r < 96) return FL_TO_HDR;
        return FL_TO_TAIL;
    endfunction

    // Wait until every beat is taken and every result is back, then let the pipeline empty.
    task automatic settle();
        while (rx_beat_q.size() != 0 || i_s_axis_tvalid || frame_result_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register at the next edge; the enable stays high until cfg_close.
    task automatic cfg_write(input t_cfg_idx idx, input logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SOF_CODE: cfg_shadow.sof_code = val[7:0];
            CFG_EOF_CODE: cfg_shadow.eof_code = val[7:0];
            CFG_IMG_KIND: cfg_shadow.img_kind = val[7:0];
            CFG_EXP_SIZE: cfg_shadow.exp_size = val;
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic cfg_write_all(input logic [7:0] sm, input logic [7:0] em,
                                 input logic [7:0] ty, input logic [23:0] sz);
        cfg_write(CFG_SOF_CODE, 24'(sm));
        cfg_write(CFG_EOF_CODE, 24'(em));
        cfg_write(CFG_IMG_KIND, 24'(ty));
        cfg_write(CFG_EXP_SIZE, sz);
        cfg_close();
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin : stim_blk
        logic [15:0] crc;
        logic [7:0]  b;
        int          phase_no;

        cfg_shadow.sof_code = SOF_CODE_RST;
        cfg_shadow.eof_code = EOF_CODE_RST;
        cfg_shadow.img_kind = IMG_KIND_RST;
        cfg_shadow.exp_size = EXP_SIZE_RST;
        restart_hunt();
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset configuration: timeout while hunting, byte extremes as noise,
        // bad type, timeout in the header, and a length whose top byte breaks the size.
        set_idle(0, 0);
        push_beat(1'b1, 8'h00);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'hAA);
        push_beat(1'b0, 8'hFE);
        push_beat(1'b0, 8'hAA);
        push_beat(1'b0, 8'h01);
        push_beat(1'b1, 8'hFF);
        push_beat(1'b0, 8'hAA);
        push_beat(1'b0, 8'h01);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'h4C);
        push_beat(1'b0, 8'h02);
        push_beat(1'b0, 8'h01);
        settle();

        // Zero size: empty payload, CRC must read back as the initial value.
        cfg_write(CFG_EXP_SIZE, 24'd0);
        cfg_close();
        push_beat(1'b0, 8'hAA);
        push_beat(1'b0, 8'h01);
        repeat (4) push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, 8'h55);
        settle();

        // Shrink the size register under a running payload: the next byte must end it.
        cfg_write_all(8'h3C, 8'hC3, 8'h5A, 24'd8);
        set_idle(51, 51);
        push_beat(1'b0, 8'h3C);
        push_beat(1'b0, 8'h5A);
        push_beat(1'b0, 8'h08);
        repeat (3) push_beat(1'b0, 8'h00);
        crc = 16'hFFFF;
        repeat (5) begin
            b = 8'($urandom);
            push_beat(1'b0, b);
            crc = crc_ccitt_step(crc, b);
        end
        settle();
        cfg_write(CFG_EXP_SIZE, 24'd3);
        cfg_close();
        b = 8'($urandom);
        push_beat(1'b0, b);
        crc = crc_ccitt_step(crc, b);
        push_beat(1'b0, crc[7:0]);
        push_beat(1'b0, crc[15:8]);
        push_beat(1'b0, 8'hC3);
        settle();

        // Back-pressure: hold the receiver off long enough to fill the block and stall intake.
        cfg_write_all(8'($urandom), 8'($urandom), 8'($urandom), 24'd40);
        set_idle(0, 0);
        repeat (5) queue_frame(FL_NONE);
        press_req = 1'b1;
        wait (hold_cnt != 0);
        press_req = 1'b0;
        settle();

        // Random phases: rotate the idling mix, visit extreme configurations, random frames.
        for (phase_no = 0; beats_queued < TOTAL_BEATS; phase_no++) begin
            case (phase_no % 4)
                0: set_idle(0, 0);
                1: set_idle(51, 0);
                2: set_idle(0, 51);
                default: set_idle(19, 19);
            endcase
            case (phase_no)
                1: cfg_write_all(8'h00, 8'h00, 8'h00, 24'd1);
                3: cfg_write_all(8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
                default: begin
                    if (phase_no == 0 || $urandom_range(1) == 0)
                        cfg_write_all(8'($urandom), 8'($urandom), 8'($urandom),
                                      ($urandom_range(7) == 0) ? 24'($urandom_range(13, 40))
                                                               : 24'($urandom_range(1, 12)));
                end
            endcase
            repeat ($urandom_range(4, 8)) begin
                if ($urandom_range(2) == 0) queue_noise();
                queue_frame(pick_flaw());
            end
            settle();
        end

        $display("Run covered %0d input beats and %0d payload beats over %0d random phases",
                 beats_in, payload_seen, phase_no);
        $display("Frame endings: ok %0d, type %0d, size %0d, crc %0d, end marker %0d, timeout %0d",
                 status_seen[ST_OK], status_seen[ST_TYPE], status_seen[ST_SIZE],
                 status_seen[ST_CRC], status_seen[ST_ENDM], status_seen[ST_TIMEOUT]);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
